// ----- design/assert_macros.svh -----
// Assertion macros for the checker file.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked outside reset.
`define AST_ON(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Property checked at every edge, reset included.
`define AST_ALWAYS(label, clk, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- design/pwq_pkg.sv -----
// Shared types and codes for the priority wait queue.
// No dependencies; imported by the cell, top level and checker.
package pwq_pkg;

	localparam int QUEUE_DEPTH_DEF = 32;

	localparam logic [1:0] CMD_SUSPEND    = 2'd0;
	localparam logic [1:0] CMD_RESUME     = 2'd1;
	localparam logic [1:0] CMD_RESUME_ALL = 2'd2;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_FULL  = 2'd1;
	localparam logic [1:0] ST_EMPTY = 2'd2;

	typedef enum logic {
		S_IDLE,
		S_DRAIN
	} ctrl_state_t;

	typedef struct packed {
		logic [7:0] task_id;
		logic [7:0] pri;
	} entry_t;

	// broadcast from the controller to every cell
	typedef struct packed {
		logic       insert;
		logic       pop;
		logic       mode;
		logic [7:0] task_id;
		logic [7:0] pri;
	} cell_ctrl_t;

endpackage

// ----- design/priority_wait_queue.sv -----
// Priority wait queue: a row of slot cells plus a command controller.
// Suspend/resume/unused: one word in the input register at a time; its result is registered.
// Resume-all of N tasks: N results, one per cycle unless the output stalls, each set by a head pop.
// Reset (arst_n low) empties the queue, selects FIFO mode, drops any pending word.
module priority_wait_queue #(
	parameter int QUEUE_DEPTH = pwq_pkg::QUEUE_DEPTH_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic       queue_mode,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [1:0] cmd,
	input  logic [7:0] task_id,
	input  logic [7:0] task_priority,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [1:0] status,
	output logic [7:0] woken_task,
	output logic       woken_with_error,
	output logic       last
);
	import pwq_pkg::*;

	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	ctrl_state_t    state_q, state_d;
	logic           mode_q;
	logic [CNT_W-1:0] count_q, count_d;
	logic           pend_q, pend_clr;
	logic [1:0]     cmd_q;
	logic [7:0]     tid_q, pri_q;

	logic           out_free, emit;
	logic [1:0]     st_d;
	logic [7:0]     wt_d;
	logic           err_d, last_d;
	logic           is_empty, is_full, is_one;

	cell_ctrl_t     ctrl;
	logic           do_insert, do_pop;
	entry_t         entries [QUEUE_DEPTH];
	logic [QUEUE_DEPTH:0] found;

	assign cfg_ready = 1'b1;
	assign in_stall  = pend_q;
	assign out_free  = !out_valid || !out_stall;
	assign is_empty  = (count_q == '0);
	assign is_full   = (count_q == CNT_W'(QUEUE_DEPTH));
	assign is_one    = (count_q == CNT_W'(1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			mode_q <= queue_mode;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= 1'b0;
		end else if (in_valid && !in_stall) begin
			pend_q <= 1'b1;
		end else if (pend_clr) begin
			pend_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			cmd_q <= cmd;
			tid_q <= task_id;
			pri_q <= task_priority;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		count_d   = count_q;
		pend_clr  = 1'b0;
		emit      = 1'b0;
		do_insert = 1'b0;
		do_pop    = 1'b0;
		st_d      = ST_OK;
		wt_d      = '0;
		err_d     = 1'b0;
		last_d    = 1'b1;
		unique case (state_q)
			S_IDLE: begin
				if (pend_q && out_free) begin
					pend_clr = 1'b1;
					emit     = 1'b1;
					unique case (cmd_q)
						CMD_SUSPEND: begin
							if (is_full) begin
								st_d = ST_FULL;
							end else begin
								do_insert = 1'b1;
								count_d   = count_q + CNT_W'(1);
							end
						end
						CMD_RESUME: begin
							if (is_empty) begin
								st_d = ST_EMPTY;
							end else begin
								do_pop  = 1'b1;
								wt_d    = entries[0].task_id;
								count_d = count_q - CNT_W'(1);
							end
						end
						CMD_RESUME_ALL: begin
							if (is_empty) begin
								st_d = ST_EMPTY;
							end else begin
								do_pop  = 1'b1;
								wt_d    = entries[0].task_id;
								err_d   = 1'b1;
								last_d  = is_one;
								count_d = count_q - CNT_W'(1);
								if (!is_one) begin
									state_d = S_DRAIN;
								end
							end
						end
						default: begin
						end
					endcase
				end
			end
			S_DRAIN: begin
				if (out_free) begin
					emit    = 1'b1;
					do_pop  = 1'b1;
					wt_d    = entries[0].task_id;
					err_d   = 1'b1;
					last_d  = is_one;
					count_d = count_q - CNT_W'(1);
					if (is_one) begin
						state_d = S_IDLE;
					end
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (emit) begin
			out_valid <= 1'b1;
		end else if (!out_stall) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			status           <= st_d;
			woken_task       <= wt_d;
			woken_with_error <= err_d;
			last             <= last_d;
		end
	end

	assign ctrl.insert  = do_insert;
	assign ctrl.pop     = do_pop;
	assign ctrl.mode    = mode_q;
	assign ctrl.task_id = tid_q;
	assign ctrl.pri     = pri_q;

	assign found[0] = 1'b0;

	for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
		entry_t prev_e, next_e;
		logic   occ;

		assign occ = (CNT_W'(i) < count_q);

		if (i == 0) begin : g_first
			assign prev_e = '0;
		end else begin : g_mid_prev
			assign prev_e = entries[i-1];
		end

		if (i == QUEUE_DEPTH - 1) begin : g_end
			assign next_e = entries[i];
		end else begin : g_mid_next
			assign next_e = entries[i+1];
		end

		pwq_cell u_cell (
			.clk        (clk),
			.ctrl       (ctrl),
			.occ        (occ),
			.found_in   (found[i]),
			.found_out  (found[i+1]),
			.prev_entry (prev_e),
			.next_entry (next_e),
			.entry      (entries[i])
		);
	end

endmodule

// ----- design/pwq_cell.sv -----
// One queue slot: holds a task ID and priority, shifts right on insert
// and left on pop. Depends on pwq_pkg.
module pwq_cell (
	input  logic                clk,
	input  pwq_pkg::cell_ctrl_t ctrl,
	input  logic                occ,
	input  logic                found_in,
	output logic                found_out,
	input  pwq_pkg::entry_t     prev_entry,
	input  pwq_pkg::entry_t     next_entry,
	output pwq_pkg::entry_t     entry
);
	import pwq_pkg::*;

	entry_t entry_q;
	logic   hit;

	// free slot, or in priority mode a strictly less urgent occupant
	assign hit       = !occ || (ctrl.mode && (ctrl.pri < entry_q.pri));
	assign found_out = found_in || hit;
	assign entry     = entry_q;

	always_ff @(posedge clk) begin
		if (ctrl.insert) begin
			if (found_in) begin
				entry_q <= prev_entry;
			end else if (hit) begin
				entry_q.task_id <= ctrl.task_id;
				entry_q.pri     <= ctrl.pri;
			end
		end else if (ctrl.pop) begin
			entry_q <= next_entry;
		end
	end

endmodule

// ----- design/pwq_checker.sv -----
// Port-level checks on the result channel of the priority wait queue.
// Depends on pwq_pkg and assert_macros.svh; bound to priority_wait_queue.
`include "assert_macros.svh"

module pwq_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_stall,
	input logic [1:0] status,
	input logic [7:0] woken_task,
	input logic       woken_with_error,
	input logic       last
);
	import pwq_pkg::*;

	`AST_ALWAYS(a_reset_idle, clk, !arst_n |-> !out_valid, "result word valid in reset")
	`AST_ON(a_hold, clk, arst_n, out_valid && out_stall |=> out_valid && $stable(woken_task), "stalled word changed")
	`AST_ON(a_err_last, clk, arst_n, out_valid && status != ST_OK |-> last, "error status word not last")
	`AST_ON(a_err_clean, clk, arst_n, out_valid && (status == ST_FULL || status == ST_EMPTY) |-> woken_task == 8'd0 && !woken_with_error, "error word carries a task")
	`AST_ON(a_woken_ok, clk, arst_n, out_valid && woken_with_error |-> status == ST_OK, "resume-all word with bad status")

endmodule

bind priority_wait_queue pwq_checker u_pwq_checker (.*);
